/* rtl/fall_detect_state_machine_assert.svh */
// Assertion macros shared by the fall detector checkers.
// Depends on nothing; the caller provides aclk and aresetn in scope.
`ifndef FALL_DETECT_STATE_MACHINE_ASSERT_SVH
`define FALL_DETECT_STATE_MACHINE_ASSERT_SVH

// Checked only while out of reset.
`define FDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define FDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/fds_pkg.sv */
// Shared types, constants and helper functions for the fall detector.
// Depends on nothing; used by every RTL module of the block.
package fds_pkg;

    localparam int ADDR_W = 4;

    // Register indexes within the configuration map (byte address = 4 * index).
    localparam logic [1:0] REG_IMPACT_THR = 2'd0;
    localparam logic [1:0] REG_ANGLE_THR  = 2'd1;
    localparam logic [1:0] REG_WINDOW_MS  = 2'd2;

    localparam logic [11:0] IMPACT_THR_RST = 12'd640;
    localparam logic [11:0] ANGLE_THR_RST  = 12'd720;
    localparam logic [31:0] WINDOW_MS_RST  = 32'd3000;

    localparam logic [31:0]        SETTLE_MS    = 32'd1000;
    localparam logic signed [14:0] HALF_TURN    = 15'sd2880;
    localparam logic signed [14:0] FULL_TURN    = 15'sd5760;
    localparam logic [11:0]        SPREAD_LIMIT = 12'd77;

    typedef struct packed {
        logic              command;
        logic [11:0]       g_magnitude;
        logic signed [12:0] pitch_angle;
        logic signed [12:0] roll_angle;
        logic [31:0]       time_ms;
    } item_t;

    typedef struct packed {
        logic [11:0] impact_threshold;
        logic [11:0] angle_threshold;
        logic [31:0] inactivity_window_ms;
    } cfg_t;

    // Absolute angle change folded onto half a turn; may go negative for
    // angles outside +/-180 degrees.
    function automatic logic signed [14:0] wrapped_diff(
        input logic signed [12:0] a,
        input logic signed [12:0] b
    );
        logic signed [13:0] d;
        logic [13:0]        mag;
        logic signed [14:0] r;
        d   = $signed({a[12], a}) - $signed({b[12], b});
        mag = d[13] ? 14'(-d) : 14'(d);
        r   = $signed({1'b0, mag});
        if (r > HALF_TURN) begin
            r = FULL_TURN - r;
        end
        return r;
    endfunction

endpackage

/* rtl/fds_cfg.sv */
// APB register file holding the detector thresholds and window length.
// Depends on fds_pkg.
module fds_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fds_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output fds_pkg::cfg_t              cfg
);

    logic [11:0] impact_thr_reg;
    logic [11:0] angle_thr_reg;
    logic [31:0] window_ms_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            impact_thr_reg <= fds_pkg::IMPACT_THR_RST;
            angle_thr_reg  <= fds_pkg::ANGLE_THR_RST;
            window_ms_reg  <= fds_pkg::WINDOW_MS_RST;
        end else if (wr_en && (paddr[1:0] == 2'b00)) begin
            case (paddr[3:2])
                fds_pkg::REG_IMPACT_THR: impact_thr_reg <= pwdata[11:0];
                fds_pkg::REG_ANGLE_THR:  angle_thr_reg  <= pwdata[11:0];
                fds_pkg::REG_WINDOW_MS:  window_ms_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fds_pkg::REG_IMPACT_THR: prdata = {20'd0, impact_thr_reg};
            fds_pkg::REG_ANGLE_THR:  prdata = {20'd0, angle_thr_reg};
            fds_pkg::REG_WINDOW_MS:  prdata = window_ms_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.impact_threshold     = impact_thr_reg;
    assign cfg.angle_threshold      = angle_thr_reg;
    assign cfg.inactivity_window_ms = window_ms_reg;

endmodule

/* rtl/fds_step.sv */
// Four-phase fall detection machine: state registers and next-state logic.
// Depends on fds_pkg.
module fds_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  fds_pkg::item_t item,
    input  fds_pkg::cfg_t  cfg,
    output logic [1:0]    fall_status_next
);

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_IMPACT = 2'd1,
        PH_CHECK  = 2'd2,
        PH_FALL   = 2'd3
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [31:0]        start_reg,  start_next;
    logic signed [12:0] bpitch_reg, bpitch_next;
    logic signed [12:0] broll_reg,  broll_next;
    logic [11:0]        peak_reg,   peak_next;
    logic [11:0]        floor_reg,  floor_next;

    logic [31:0]        elapsed;
    logic signed [14:0] dp, dr, ang_thr;
    logic               drastic;
    logic [11:0]        peak_upd, floor_upd;
    logic [12:0]        spread;
    logic               still;

    always_comb begin
        elapsed   = item.time_ms - start_reg;
        dp        = fds_pkg::wrapped_diff(bpitch_reg, item.pitch_angle);
        dr        = fds_pkg::wrapped_diff(broll_reg, item.roll_angle);
        ang_thr   = $signed({3'b000, cfg.angle_threshold});
        drastic   = (dp > ang_thr) || (dr > ang_thr);
        peak_upd  = (item.g_magnitude > peak_reg)  ? item.g_magnitude : peak_reg;
        floor_upd = (item.g_magnitude < floor_reg) ? item.g_magnitude : floor_reg;
        // Borrow out means floor above peak: never counts as still.
        spread    = {1'b0, peak_upd} - {1'b0, floor_upd};
        still     = !spread[12] && (spread[11:0] < fds_pkg::SPREAD_LIMIT);

        phase_next  = phase_reg;
        start_next  = start_reg;
        bpitch_next = bpitch_reg;
        broll_next  = broll_reg;
        peak_next   = peak_reg;
        floor_next  = floor_reg;

        if (item.command) begin
            phase_next = PH_NORMAL;
        end else begin
            case (phase_reg)
                PH_NORMAL: begin
                    bpitch_next = item.pitch_angle;
                    broll_next  = item.roll_angle;
                    if (item.g_magnitude > cfg.impact_threshold) begin
                        phase_next = PH_IMPACT;
                        start_next = item.time_ms;
                    end
                end
                PH_IMPACT: begin
                    if (elapsed > fds_pkg::SETTLE_MS) begin
                        if (drastic) begin
                            phase_next = PH_CHECK;
                            start_next = item.time_ms;
                            peak_next  = item.g_magnitude;
                            floor_next = item.g_magnitude;
                        end else begin
                            phase_next = PH_NORMAL;
                        end
                    end
                end
                PH_CHECK: begin
                    peak_next  = peak_upd;
                    floor_next = floor_upd;
                    if (elapsed > cfg.inactivity_window_ms) begin
                        phase_next = still ? PH_FALL : PH_NORMAL;
                    end
                end
                PH_FALL: ;
                default: phase_next = PH_NORMAL;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_NORMAL;
            start_reg  <= 32'd0;
            bpitch_reg <= 13'sd0;
            broll_reg  <= 13'sd0;
            peak_reg   <= 12'd0;
            floor_reg  <= 12'd0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            bpitch_reg <= bpitch_next;
            broll_reg  <= broll_next;
            peak_reg   <= peak_next;
            floor_reg  <= floor_next;
        end
    end

    assign fall_status_next = phase_next;

endmodule

/* rtl/fall_detect_state_machine.sv */
// Top level of the fall detector: stream ports, input and result registers.
// Depends on fds_pkg, fds_cfg and fds_step.
//
// Path: an accepted item is held in the input register; on advance it is
// stepped and its status registered into the result register on m_tdata.
// Throughput: one item per cycle unless m_tready stalls; the only serial
// dependency is the fds_step phase/history registers, updated on advance.
// Reset: aresetn is synchronous, active low; it empties both registers,
// returns the machine to normal with zeroed history and reloads the defaults.
module fall_detect_state_machine (
    input  logic                       aclk,
    input  logic                       aresetn,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fds_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [71:0]                s_tdata,  // g_magnitude[11:0], pitch_angle[24:12],
                                                 // roll_angle[37:25], time_ms[69:38], zero
    input  logic                       s_tuser,  // command (1 = clear)
    // Result items
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata   // fall_status[1:0], zero above
);

    fds_pkg::cfg_t  cfg;
    fds_pkg::item_t in_item_reg;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic [1:0]     out_status_reg;
    logic [1:0]     fall_status_next;
    logic           advance;

    fds_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Step the held item whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new item when the input register empties this cycle or is empty.
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: capture on every accepted item, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command     <= s_tuser;
            in_item_reg.g_magnitude <= s_tdata[11:0];
            in_item_reg.pitch_angle <= $signed(s_tdata[24:12]);
            in_item_reg.roll_angle  <= $signed(s_tdata[37:25]);
            in_item_reg.time_ms     <= s_tdata[69:38];
        end
    end

    fds_step u_step (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .item             (in_item_reg),
        .cfg              (cfg),
        .fall_status_next (fall_status_next)
    );

    // Result register: load on advance, drop the item once taken downstream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= fall_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg};

endmodule

/* rtl/fds_checker.sv */
// Port-level checker for the fall detector, bound to the top level.
// Depends on fall_detect_state_machine_assert.svh and fds_pkg.
`include "fall_detect_state_machine_assert.svh"

module fds_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [fds_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [71:0]                s_tdata,
    input logic                       s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [7:0]                 m_tdata
);

    // Hold a stalled result.
    `FDS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // No result straight after reset.
    `FDS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // An empty output side never blocks the input side.
    `FDS_ASSERT(a_no_idle_stall, !m_tvalid |-> s_tready, "input stalled with output empty")

    // A result drained while the input side is blocked reopens the input side.
    `FDS_ASSERT(a_drain_open, m_tvalid && m_tready && !s_tready |=> s_tready, "input blocked after drain")

endmodule

bind fall_detect_state_machine fds_checker u_fds_checker (.*);
